/* rtl/core/scio_pkg.sv */
// Shared constants, types and helper functions for the sound I/O page block.
package scio_pkg;

    // DSP register file depth, valid range 16 to 128
    localparam int DSP_REG_COUNT = 128;
    localparam int DSP_AW        = $clog2(DSP_REG_COUNT);

    // Function codes of an input word
    localparam logic [2:0] FUNC_SND_RD  = 3'd0;
    localparam logic [2:0] FUNC_SND_WR  = 3'd1;
    localparam logic [2:0] FUNC_MAIN_RD = 3'd2;
    localparam logic [2:0] FUNC_MAIN_WR = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    // Page register indexes (address minus 0xF0)
    localparam logic [3:0] REG_CONTROL  = 4'h1;
    localparam logic [3:0] REG_DSP_ADDR = 4'h2;
    localparam logic [3:0] REG_DSP_DATA = 4'h3;
    localparam logic [3:0] REG_PORT0    = 4'h4;
    localparam logic [3:0] REG_PORT1    = 4'h5;
    localparam logic [3:0] REG_PORT2    = 4'h6;
    localparam logic [3:0] REG_PORT3    = 4'h7;
    localparam logic [3:0] REG_TIMER0   = 4'hA;
    localparam logic [3:0] REG_TIMER1   = 4'hB;
    localparam logic [3:0] REG_TIMER2   = 4'hC;
    localparam logic [3:0] REG_COUNTER0 = 4'hD;
    localparam logic [3:0] REG_COUNTER1 = 4'hE;
    localparam logic [3:0] REG_COUNTER2 = 4'hF;

    localparam int NUM_TIMERS = 3;

    // Per-timer control strobes for one processed word
    typedef struct packed {
        logic tick;     // advance divider by the cycle count
        logic clr;      // clear stage and output counters
        logic rd_clr;   // output counter read, clear it
        logic tgt_we;   // load target from write data
    } t_tmr_ctl;

    // Prescaler period of each timer
    function automatic logic [7:0] timer_divisor(input logic [1:0] idx);
        logic [7:0] d;
        case (idx)
            2'd0:    d = 8'd128;
            2'd1:    d = 8'd128;
            2'd2:    d = 8'd16;
            default: d = 8'd128;
        endcase
        return d;
    endfunction

    // Mask index to 7 bits and fold it into the register file depth
    function automatic logic [DSP_AW-1:0] dsp_slot(input logic [7:0] idx);
        logic [6:0] v;
        v = idx[6:0];
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, v} >= 8'(DSP_REG_COUNT)) begin
                v = 7'({1'b0, v} - 8'(DSP_REG_COUNT));
            end
        end
        return v[DSP_AW-1:0];
    endfunction

endpackage

/* rtl/core/scio_dsp_ram.sv */
// DSP register file: one write port, one registered read port, valid bits.
module scio_dsp_ram (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [scio_pkg::DSP_AW-1:0]  i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic [scio_pkg::DSP_AW-1:0]  i_raddr,
    output logic [7:0]                   o_rdata
);
    import scio_pkg::*;

    logic [7:0]               r_mem [DSP_REG_COUNT];
    logic [DSP_REG_COUNT-1:0] r_vld;
    logic [7:0]               r_q;
    logic                     r_q_vld;
    logic                     r_byp;
    logic [7:0]               r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q        <= r_mem[i_raddr];
        r_byp_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_q_vld <= r_vld[i_raddr];
            // forward a same-cycle write to the read side
            r_byp   <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp ? r_byp_data : (r_q_vld ? r_q : 8'h00);

endmodule

/* rtl/core/scio_timer.sv */
// One interval timer: prescaler, stage counter, target and 4-bit output counter.
module scio_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scio_pkg::t_tmr_ctl i_ctl,
    input  logic [3:0]         i_cycles,
    input  logic [7:0]         i_wdata,
    input  logic [7:0]         i_divisor,
    output logic [3:0]         o_count
);
    import scio_pkg::*;

    logic [6:0] r_div,    n_div;
    logic [7:0] r_stage,  n_stage;
    logic [7:0] r_target, n_target;
    logic [3:0] r_out,    n_out;
    logic [7:0] sum;
    logic       wrap;
    logic [7:0] stage_inc;
    logic       hit;

    assign sum       = {1'b0, r_div} + {4'b0000, i_cycles};
    assign wrap      = (sum >= i_divisor);
    assign stage_inc = r_stage + 8'd1;
    assign hit       = (stage_inc == r_target);

    always_comb begin
        n_div    = r_div;
        n_stage  = r_stage;
        n_target = r_target;
        n_out    = r_out;
        if (i_ctl.tick) begin
            n_div = wrap ? 7'(sum - i_divisor) : sum[6:0];
            if (wrap) begin
                n_stage = hit ? 8'd0 : stage_inc;
                n_out   = hit ? r_out + 4'd1 : r_out;
            end
        end
        if (i_ctl.clr) begin
            n_stage = 8'd0;
            n_out   = 4'd0;
        end
        if (i_ctl.rd_clr) begin
            n_out = 4'd0;
        end
        if (i_ctl.tgt_we) begin
            n_target = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= '0;
            r_stage  <= '0;
            r_target <= '0;
            r_out    <= '0;
        end else begin
            r_div    <= n_div;
            r_stage  <= n_stage;
            r_target <= n_target;
            r_out    <= n_out;
        end
    end

    assign o_count = r_out;

endmodule

/* rtl/core/sound_cpu_io_page_and_timers.sv */
// Top level: sound I/O page decode, mailboxes, timers and word pipeline.
// An accepted input word passes the input register, then the page/timer update and
// the result register in one pass to become its result word.
// Throughput: one word per cycle while the result side does not stall; the result register frees as it is taken.
// Reset (synchronous, active low): all page state, mailboxes, timers and DSP
// file read as zero, boot ROM is mapped, both pipeline stages are empty.
module sound_cpu_io_page_and_timers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    input  logic [3:0] i_reg_index,
    input  logic [7:0] i_wdata,
    input  logic [3:0] i_cycles,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_rdata,
    output logic       o_boot_rom_mapped
);
    import scio_pkg::*;

    // ---------------- pipeline control ----------------
    logic       r_in_vld;
    logic [2:0] r_func;
    logic [3:0] r_reg;
    logic [7:0] r_wdata;
    logic [3:0] r_cycles;
    logic       r_out_vld;
    logic [7:0] r_rdata;
    logic       r_rom_out;

    logic out_load;   // result register can take a word this cycle
    logic fire;       // the held word is processed and retires
    logic accept;

    assign out_load = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_load;
    assign o_stall  = r_in_vld && !out_load;
    assign accept   = i_valid && !o_stall;

    // ---------------- page state ----------------
    logic [2:0] r_tmr_en,     n_tmr_en;      // control bits 0..2
    logic [7:0] r_dsp_index,  n_dsp_index;
    logic [7:0] r_snd_mail [4];
    logic [7:0] n_snd_mail [4];
    logic [7:0] r_main_mail [4];
    logic [7:0] n_main_mail [4];
    logic [7:0] r_page [16];
    logic [7:0] n_page [16];
    logic       r_rom,        n_rom;

    logic [7:0]  rd;
    logic        dsp_we;
    logic [7:0]  dsp_q;
    logic [3:0]  tmr_count [NUM_TIMERS];
    t_tmr_ctl    tmr_ctl   [NUM_TIMERS];
    logic [1:0]  cnt_idx;
    logic [1:0]  tgt_idx;

    assign cnt_idx = 2'(r_reg - REG_COUNTER0);
    assign tgt_idx = 2'(r_reg - REG_TIMER0);

    // Decode the held word; state moves only when it retires
    always_comb begin
        n_tmr_en    = r_tmr_en;
        n_dsp_index = r_dsp_index;
        n_snd_mail  = r_snd_mail;
        n_main_mail = r_main_mail;
        n_page      = r_page;
        n_rom       = r_rom;
        rd          = 8'h00;
        dsp_we      = 1'b0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            tmr_ctl[t] = '0;
        end
        if (fire) begin
            case (r_func)
                FUNC_SND_RD: begin
                    case (r_reg)
                        REG_DSP_ADDR: rd = r_dsp_index;
                        REG_DSP_DATA: rd = dsp_q;
                        REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: begin
                            rd = r_snd_mail[r_reg[1:0]];
                        end
                        REG_COUNTER0, REG_COUNTER1, REG_COUNTER2: begin
                            // read-to-clear output counter
                            rd = {4'h0, tmr_count[cnt_idx]};
                            tmr_ctl[cnt_idx].rd_clr = 1'b1;
                        end
                        default: rd = r_page[r_reg];
                    endcase
                end
                FUNC_SND_WR: begin
                    case (r_reg)
                        REG_CONTROL: begin
                            n_tmr_en = r_wdata[2:0];
                            if (r_wdata[4]) begin
                                n_snd_mail[0] = 8'h00;
                                n_snd_mail[1] = 8'h00;
                            end
                            if (r_wdata[5]) begin
                                n_snd_mail[2] = 8'h00;
                                n_snd_mail[3] = 8'h00;
                            end
                            n_rom = r_wdata[7];
                            for (int t = 0; t < NUM_TIMERS; t++) begin
                                tmr_ctl[t].clr = r_wdata[t];
                            end
                        end
                        REG_DSP_ADDR: n_dsp_index = r_wdata;
                        REG_DSP_DATA: dsp_we = 1'b1;
                        REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: begin
                            n_main_mail[r_reg[1:0]] = r_wdata;
                        end
                        REG_TIMER0, REG_TIMER1, REG_TIMER2: begin
                            tmr_ctl[tgt_idx].tgt_we = 1'b1;
                        end
                        default: n_page[r_reg] = r_wdata;
                    endcase
                end
                FUNC_MAIN_RD: rd = r_main_mail[r_reg[1:0]];
                FUNC_MAIN_WR: n_snd_mail[r_reg[1:0]] = r_wdata;
                FUNC_TICK: begin
                    // advance only the enabled timers
                    for (int t = 0; t < NUM_TIMERS; t++) begin
                        tmr_ctl[t].tick = r_tmr_en[t];
                    end
                end
                default: rd = 8'h00;
            endcase
        end
    end

    // ---------------- DSP register file ----------------
    // Read at the index that the next word will see; write at the current one.
    scio_dsp_ram u_dsp_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (dsp_we),
        .i_waddr (dsp_slot(r_dsp_index)),
        .i_wdata (r_wdata),
        .i_raddr (dsp_slot(n_dsp_index)),
        .o_rdata (dsp_q)
    );

    // ---------------- timers ----------------
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        scio_timer u_timer (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (tmr_ctl[g]),
            .i_cycles  (r_cycles),
            .i_wdata   (r_wdata),
            .i_divisor (timer_divisor(2'(g))),
            .o_count   (tmr_count[g])
        );
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_tmr_en    <= '0;
            r_dsp_index <= '0;
            r_rom       <= 1'b1;
            for (int k = 0; k < 4; k++) begin
                r_snd_mail[k]  <= '0;
                r_main_mail[k] <= '0;
            end
            for (int k = 0; k < 16; k++) begin
                r_page[k] <= '0;
            end
        end else begin
            // hold the input word until it retires
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            // drop the result once taken
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            r_tmr_en    <= n_tmr_en;
            r_dsp_index <= n_dsp_index;
            r_rom       <= n_rom;
            r_snd_mail  <= n_snd_mail;
            r_main_mail <= n_main_mail;
            r_page      <= n_page;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_reg    <= i_reg_index;
            r_wdata  <= i_wdata;
            r_cycles <= i_cycles;
        end
        if (fire) begin
            r_rdata   <= rd;
            r_rom_out <= n_rom;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_rdata           = r_rdata;
    assign o_boot_rom_mapped = r_rom_out;

endmodule

/* verif/tb_sound_cpu_io_page_and_timers.sv */
// Self-checking testbench for the sound I/O page, its mailboxes and its three timers.
`timescale 1ns / 1ps

module tb_sound_cpu_io_page_and_timers;
    import scio_pkg::*;

    // Bound the whole run.
    localparam int CYCLE_LIMIT  = 200000;
    // Idle time after the last result: covers the two-stage pipe with margin.
    localparam int DRAIN_CYCLES = 20;

    // One input word as the sender sees it
    typedef struct packed {
        logic [2:0] func;
        logic [3:0] reg_index;
        logic [7:0] wdata;
        logic [3:0] cycles;
    } t_page_word;

    // One result word
    typedef struct packed {
        logic [7:0] rdata;
        logic       rom_on;
    } t_page_reply;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [2:0] i_func;
    logic [3:0] i_reg_index;
    logic [7:0] i_wdata;
    logic [3:0] i_cycles;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_rdata;
    logic       o_boot_rom_mapped;

    // Pacing knobs: percent of cycles each side spends idle or stalled
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Long receiver hold-off, counted down by the result-side process
    int hold_cycles = 0;
    int fault_count = 0;
    int cycle_count = 0;

    // Results predicted for accepted words, oldest first
    t_page_reply expected_replies[$];

    // Predicted page state
    logic [7:0] m_control;
    logic [7:0] m_dsp_index;
    logic [7:0] m_dsp_file  [DSP_REG_COUNT];
    logic [7:0] m_to_sound  [4];
    logic [7:0] m_to_main   [4];
    logic [7:0] m_target    [NUM_TIMERS];
    logic [7:0] m_stage     [NUM_TIMERS];
    logic [3:0] m_count     [NUM_TIMERS];
    logic [6:0] m_prescale  [NUM_TIMERS];
    logic [7:0] m_page      [16];
    logic       m_rom_on;

    always #5 i_clk = ~i_clk;

    sound_cpu_io_page_and_timers DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_reg_index       (i_reg_index),
        .i_wdata           (i_wdata),
        .i_cycles          (i_cycles),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_rdata           (o_rdata),
        .o_boot_rom_mapped (o_boot_rom_mapped)
    );

    // Apply one accepted word to the predicted page state and return the result
    // it must produce.
    function automatic t_page_reply predict_page_access(input t_page_word w);
        t_page_reply r;
        int slot;
        int acc;
        int per;
        int t;
        r.rdata = 8'h00;
        // The index is folded to 7 bits, then into the file depth
        slot = int'(m_dsp_index[6:0]) % DSP_REG_COUNT;
        case (w.func)
            FUNC_SND_RD: begin
                case (w.reg_index)
                    REG_DSP_ADDR: r.rdata = m_dsp_index;
                    REG_DSP_DATA: r.rdata = m_dsp_file[slot];
                    REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
                        r.rdata = m_to_sound[w.reg_index[1:0]];
                    REG_COUNTER0, REG_COUNTER1, REG_COUNTER2: begin
                        // Read-to-clear output counter
                        r.rdata = {4'h0, m_count[w.reg_index - REG_COUNTER0]};
                        m_count[w.reg_index - REG_COUNTER0] = 4'h0;
                    end
                    // Control and target addresses never reach the page store,
                    // so they read back as zero here
                    default: r.rdata = m_page[w.reg_index];
                endcase
            end
            FUNC_SND_WR: begin
                case (w.reg_index)
                    REG_CONTROL: begin
                        m_control = w.wdata;
                        if (w.wdata[4]) begin
                            m_to_sound[0] = 8'h00;
                            m_to_sound[1] = 8'h00;
                        end
                        if (w.wdata[5]) begin
                            m_to_sound[2] = 8'h00;
                            m_to_sound[3] = 8'h00;
                        end
                        m_rom_on = w.wdata[7];
                        for (t = 0; t < NUM_TIMERS; t++) begin
                            if (w.wdata[t]) begin
                                m_stage[t] = 8'h00;
                                m_count[t] = 4'h0;
                            end
                        end
                    end
                    REG_DSP_ADDR: m_dsp_index = w.wdata;
                    REG_DSP_DATA: m_dsp_file[slot] = w.wdata;
                    REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3:
                        m_to_main[w.reg_index[1:0]] = w.wdata;
                    REG_TIMER0, REG_TIMER1, REG_TIMER2:
                        m_target[w.reg_index - REG_TIMER0] = w.wdata;
                    default: m_page[w.reg_index] = w.wdata;
                endcase
            end
            FUNC_MAIN_RD: r.rdata = m_to_main[w.reg_index[1:0]];
            FUNC_MAIN_WR: m_to_sound[w.reg_index[1:0]] = w.wdata;
            FUNC_TICK: begin
                for (t = 0; t < NUM_TIMERS; t++) begin
                    // A disabled timer keeps divider, stage and output as they are
                    if (m_control[t]) begin
                        per = (t == 2) ? 16 : 128;
                        acc = int'(m_prescale[t]) + int'(w.cycles);
                        while (acc >= per) begin
                            acc -= per;
                            // 8-bit stage wraps 255 to 0, so a zero target
                            // gives a period of 256
                            m_stage[t] = m_stage[t] + 8'd1;
                            if (m_stage[t] == m_target[t]) begin
                                m_stage[t] = 8'h00;
                                m_count[t] = m_count[t] + 4'd1;
                            end
                        end
                        m_prescale[t] = acc[6:0];
                    end
                end
            end
            default: ;
        endcase
        r.rom_on = m_rom_on;
        return r;
    endfunction

    // Draw a random word, weighted toward timer activity and counter reads so
    // that the output counters actually move between reads.
    function automatic t_page_word random_word();
        t_page_word w;
        int pick;
        pick        = $urandom_range(99);
        w.reg_index = 4'($urandom_range(15));
        w.wdata     = 8'($urandom_range(255));
        w.cycles    = 4'($urandom_range(15));
        if (pick < 38) begin
            w.func = FUNC_TICK;
        end else if (pick < 50) begin
            w.func = FUNC_SND_RD;
            if ($urandom_range(1) == 1) begin
                w.reg_index = REG_COUNTER0 + 4'($urandom_range(2));
            end
        end else if (pick < 53) begin
            // Control write: usually keep all timers running
            w.func      = FUNC_SND_WR;
            w.reg_index = REG_CONTROL;
            if ($urandom_range(3) != 0) begin
                w.wdata[2:0] = 3'b111;
            end
        end else if (pick < 58) begin
            // Short targets make the output counters move quickly
            w.func      = FUNC_SND_WR;
            w.reg_index = REG_TIMER0 + 4'($urandom_range(2));
            if ($urandom_range(3) != 0) begin
                w.wdata = 8'($urandom_range(3));
            end
        end else if (pick < 70) begin
            w.func = FUNC_SND_WR;
        end else if (pick < 85) begin
            w.func = FUNC_MAIN_RD;
        end else begin
            w.func = FUNC_MAIN_WR;
        end
        return w;
    endfunction

    // Offer one word and hold it until the block takes it, then record the
    // result it must produce. Valid stays high on return so that back-to-back
    // words need no second assignment in one step.
    task automatic send_word(input logic [2:0] func, input logic [3:0] reg_index,
                             input logic [7:0] wdata, input logic [3:0] cycles);
        t_page_word w;
        w = {func, reg_index, wdata, cycles};
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= func;
        i_reg_index <= reg_index;
        i_wdata     <= wdata;
        i_cycles    <= cycles;
        do @(posedge i_clk); while (o_stall);
        expected_replies.push_back(predict_page_access(w));
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_for_replies;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    // Mailboxes in both directions, their clears, the boot ROM bit, the DSP
    // index and data ports, the page store and the zero-reading addresses.
    task automatic test_page_registers;
        // Main side: upper index bits are ignored
        send_word(FUNC_MAIN_WR, 4'd0,  8'hFF, 4'd0);
        send_word(FUNC_MAIN_WR, 4'd15, 8'hA5, 4'd0);
        send_word(FUNC_MAIN_WR, 4'd5,  8'h5A, 4'd0);
        send_word(FUNC_MAIN_WR, 4'd10, 8'h81, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT0, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT1, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT2, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT3, 8'h00, 4'd0);
        // Clear ports 0 and 1, unmap the boot ROM
        send_word(FUNC_SND_WR, REG_CONTROL, 8'h10, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT0, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT2, 8'h00, 4'd0);
        // Clear ports 2 and 3, map the boot ROM again
        send_word(FUNC_SND_WR, REG_CONTROL, 8'hA0, 4'd0);
        send_word(FUNC_SND_RD, REG_PORT3, 8'h00, 4'd0);
        // Sound to main direction
        send_word(FUNC_SND_WR, REG_PORT0, 8'hFF, 4'd0);
        send_word(FUNC_SND_WR, REG_PORT3, 8'h00, 4'd0);
        send_word(FUNC_MAIN_RD, 4'd4,  8'h00, 4'd0);
        send_word(FUNC_MAIN_RD, 4'd15, 8'h00, 4'd0);
        // DSP index with bit 7 set aliases onto the entry with bit 7 clear
        send_word(FUNC_SND_WR, REG_DSP_ADDR, 8'hFF, 4'd0);
        send_word(FUNC_SND_WR, REG_DSP_DATA, 8'h3C, 4'd0);
        send_word(FUNC_SND_WR, REG_DSP_ADDR, 8'h7F, 4'd0);
        send_word(FUNC_SND_RD, REG_DSP_DATA, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_DSP_ADDR, 8'h00, 4'd0);
        // Page store at both ends; a write to a counter address lands in the
        // store and leaves the counter alone
        send_word(FUNC_SND_WR, 4'd0, 8'hFF, 4'd0);
        send_word(FUNC_SND_WR, REG_COUNTER2, 8'h81, 4'd0);
        send_word(FUNC_SND_RD, 4'd0, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_COUNTER2, 8'h00, 4'd0);
        // Control and target addresses read back as zero
        send_word(FUNC_SND_WR, REG_TIMER0, 8'hFF, 4'd0);
        send_word(FUNC_SND_RD, REG_TIMER0, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_CONTROL, 8'h00, 4'd0);
    endtask

    // Timer enable and clear, divider wrap, output counter wrap from 15 to 0,
    // read-to-clear and a tick on disabled timers.
    task automatic test_timer_basics;
        send_word(FUNC_SND_WR, REG_TIMER0, 8'h01, 4'd0);
        send_word(FUNC_SND_WR, REG_TIMER1, 8'hFF, 4'd0);
        send_word(FUNC_SND_WR, REG_TIMER2, 8'h01, 4'd0);
        send_word(FUNC_SND_WR, REG_CONTROL, 8'h87, 4'd0);
        send_word(FUNC_TICK, 4'd0, 8'h00, 4'd0);
        // 270 cycles: the fast timer counts 16 periods and wraps to zero
        repeat (18) send_word(FUNC_TICK, 4'd0, 8'h00, 4'd15);
        send_word(FUNC_SND_RD, REG_COUNTER2, 8'h00, 4'd0);
        send_word(FUNC_TICK, 4'd15, 8'hFF, 4'd15);
        send_word(FUNC_SND_RD, REG_COUNTER2, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_COUNTER2, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_COUNTER0, 8'h00, 4'd0);
        send_word(FUNC_SND_RD, REG_COUNTER1, 8'h00, 4'd0);
        // Disable the slow timers; their dividers must hold
        send_word(FUNC_SND_WR, REG_CONTROL, 8'h04, 4'd0);
        repeat (2) send_word(FUNC_TICK, 4'd0, 8'h00, 4'd15);
        send_word(FUNC_SND_RD, REG_COUNTER0, 8'h00, 4'd0);
    endtask

    // A zero target must give a period of 256 stage steps
    task automatic test_zero_target;
        send_word(FUNC_SND_WR, REG_TIMER2, 8'h00, 4'd0);
        send_word(FUNC_SND_WR, REG_CONTROL, 8'h84, 4'd0);
        repeat (400) begin
            send_word(FUNC_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)),
                      4'($urandom_range(8, 15)));
        end
        send_word(FUNC_SND_RD, REG_COUNTER2, 8'h00, 4'd0);
    endtask

    // Random traffic at one pacing setting, with a full drain halfway through
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        t_page_word w;
        wait_for_replies();
        // Change pacing off the rising edge, then resume on it
        @(negedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(posedge i_clk);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                wait_for_replies();
            end
            w = random_word();
            send_word(w.func, w.reg_index, w.wdata, w.cycles);
        end
    endtask

    // Hold the result side off for a long stretch while words keep coming, so
    // the pipe fills and the block stalls its input
    task automatic test_receiver_holdoff;
        t_page_word w;
        wait_for_replies();
        @(negedge i_clk);
        hold_cycles = 300;
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        @(posedge i_clk);
        repeat (80) begin
            w = random_word();
            send_word(w.func, w.reg_index, w.wdata, w.cycles);
        end
    endtask

    // Result side: check each word taken, then pick the next stall value
    always @(posedge i_clk) begin : result_side
        t_page_reply want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("result word with none expected: rdata=%0h rom=%0b",
                           o_rdata, o_boot_rom_mapped);
                    fault_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_rdata !== want.rdata) begin
                        $error("rdata: expected %0h, got %0h", want.rdata, o_rdata);
                        fault_count++;
                    end
                    if (o_boot_rom_mapped !== want.rom_on) begin
                        $error("boot_rom_mapped: expected %0b, got %0b",
                               want.rom_on, o_boot_rom_mapped);
                        fault_count++;
                    end
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int k;
        // Hold reset and drive every input to a known value
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_func      <= FUNC_SND_RD;
        i_reg_index <= 4'd0;
        i_wdata     <= 8'h00;
        i_cycles    <= 4'd0;
        // Predicted state after reset
        m_control   = 8'h00;
        m_dsp_index = 8'h00;
        m_rom_on    = 1'b1;
        for (k = 0; k < DSP_REG_COUNT; k++) m_dsp_file[k] = 8'h00;
        for (k = 0; k < 4; k++) begin
            m_to_sound[k] = 8'h00;
            m_to_main[k]  = 8'h00;
        end
        for (k = 0; k < NUM_TIMERS; k++) begin
            m_target[k]   = 8'h00;
            m_stage[k]    = 8'h00;
            m_count[k]    = 4'h0;
            m_prescale[k] = 7'h00;
        end
        for (k = 0; k < 16; k++) m_page[k] = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_page_registers();
        test_timer_basics();
        test_zero_target();
        // Sender light and receiver heavy, then the reverse, then full rate
        test_random_traffic(16, 65, 450);
        test_random_traffic(65, 16, 450);
        test_random_traffic(0, 0, 450);
        test_receiver_holdoff();

        // Drain, then give stray words time to show up
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/scio_pkg.sv
rtl/core/scio_dsp_ram.sv
rtl/core/scio_timer.sv
rtl/core/sound_cpu_io_page_and_timers.sv
verif/tb_sound_cpu_io_page_and_timers.sv
